@@ src/sdpa_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpa_pkg
// Shared widths, ASCII codes and stage item types for the signed decimal
// padded ASCII unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdpa_pkg;

    // Field and datapath widths.
    localparam int MAG_W         = 32;
    localparam int FLD_W         = 6;
    localparam int IN_W          = 48;
    localparam int CHAR_W        = 8;
    localparam int BCD_DIGITS    = 10;
    localparam int DIG_W         = 4;
    localparam int IDX_W         = 4;
    localparam int TOT_W         = 7;

    // Double-dabble partitioning: shift steps per stage and stage count.
    localparam int DAB_STEPS     = 4;
    localparam int DAB_STAGES    = MAG_W / DAB_STEPS;

    // Default saturation width of the text.
    localparam int DEF_MAX_WIDTH = 32;

    // Character codes.
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Item moving through the conversion stages.
    typedef struct packed {
        logic                                neg;
        logic [MAG_W-1:0]                    bin;
        logic [BCD_DIGITS-1:0][DIG_W-1:0]    bcd;
        logic [FLD_W-1:0]                    min_width;
        logic [FLD_W-1:0]                    min_digits;
    } conv_t;

    // Item handed to the character serializer.
    typedef struct packed {
        logic                                neg;
        logic [TOT_W-1:0]                    total;
        logic [IDX_W-1:0]                    ndig;
        logic [BCD_DIGITS-1:0][DIG_W-1:0]    digits;
    } emit_t;

endpackage

`default_nettype wire

@@ src/signed_decimal_padded_ascii_unit.sv @@
// Path: an accepted item is loaded into the input stage, then passes the 8
// conversion stages, sizing, the serializer load and the output register.
// Throughput: one character per cycle while m_tready is high; a number has
// 1 to MAX_WIDTH characters, and the serializer loads the next number as it
// sends the last character of the one before.
// Reset: rst_n asynchronous, active low, empties all stages and the output.
// ----------------------------------------------------------------------------
// signed_decimal_padded_ascii_unit
// Converts a signed 32-bit integer into zero padded decimal ASCII text, one
// character per output item, with tlast on the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_padded_ascii_unit #(
    parameter int MAX_WIDTH = sdpa_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: value[31:0], min_width[37:32], min_digits[43:38], zeros.
    input  wire logic [sdpa_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // Fields from bit 0: char_out[7:0].
    output logic [sdpa_pkg::CHAR_W-1:0]      m_tdata,
    output logic                             m_tlast
);
    import sdpa_pkg::*;

    logic  dab_valid [DAB_STAGES+1];
    logic  dab_ready [DAB_STAGES+1];
    conv_t dab_item  [DAB_STAGES+1];
    logic  size_valid;
    logic  size_ready;
    emit_t size_item;

    // Sign and magnitude.
    sdpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (dab_valid[0]),
        .out_ready (dab_ready[0]),
        .out_item  (dab_item[0])
    );

    // Binary to BCD conversion chain.
    for (genvar g = 0; g < DAB_STAGES; g++)
    begin : g_dabble
        sdpa_dabble u_dabble (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dab_valid[g]),
            .in_ready  (dab_ready[g]),
            .in_item   (dab_item[g]),
            .out_valid (dab_valid[g+1]),
            .out_ready (dab_ready[g+1]),
            .out_item  (dab_item[g+1])
        );
    end

    // Digit count and text width.
    sdpa_size #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_size (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dab_valid[DAB_STAGES]),
        .in_ready  (dab_ready[DAB_STAGES]),
        .in_item   (dab_item[DAB_STAGES]),
        .out_valid (size_valid),
        .out_ready (size_ready),
        .out_item  (size_item)
    );

    // Character serializer.
    sdpa_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (size_valid),
        .in_ready (size_ready),
        .in_item  (size_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_char   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

`default_nettype wire

@@ src/sdpa_front.sv @@
// ----------------------------------------------------------------------------
// sdpa_front
// Input stage: splits the packed input item, takes the sign and forms the
// unsigned magnitude that feeds the decimal conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpa_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [sdpa_pkg::IN_W-1:0] in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output sdpa_pkg::conv_t                out_item
);
    import sdpa_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    conv_t            item_reg;
    conv_t            item_next;
    logic [MAG_W-1:0] raw;

    assign raw      = in_data[MAG_W-1:0];
    assign in_ready = !valid_reg || out_ready;

    // Sign and magnitude; the most negative value wraps to 2^31 unsigned.
    always_comb
    begin
        item_next            = '0;
        item_next.neg        = raw[MAG_W-1];
        item_next.bin        = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
        item_next.min_width  = in_data[MAG_W+FLD_W-1:MAG_W];
        item_next.min_digits = in_data[MAG_W+2*FLD_W-1:MAG_W+FLD_W];
    end

    // Stage valid bit.
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ src/sdpa_dabble.sv @@
// ----------------------------------------------------------------------------
// sdpa_dabble
// One stage of the shift-and-add-3 binary to BCD conversion. Each stage
// performs a fixed number of shift steps on the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpa_dabble (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sdpa_pkg::conv_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output sdpa_pkg::conv_t out_item
);
    import sdpa_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    conv_t item_reg;
    conv_t item_next;

    assign in_ready = !valid_reg || out_ready;

    // For each of the DAB_STEPS steps, correct every digit of five or more, then
    // shift one bit of the magnitude into the digit chain.
    always_comb
    begin
        item_next = in_item;
        for (int s = 0; s < DAB_STEPS; s++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (item_next.bcd[d] >= 4'd5)
                begin
                    item_next.bcd[d] = item_next.bcd[d] + 4'd3;
                end
            end
            {item_next.bcd, item_next.bin} = {item_next.bcd, item_next.bin} << 1;
        end
    end

    // Stage valid bit.
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ src/sdpa_size.sv @@
// ----------------------------------------------------------------------------
// sdpa_size
// Sizing stage: counts the significant digits and works out the total text
// width from the minimum width, the minimum digit count and the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpa_size #(
    parameter int MAX_WIDTH = sdpa_pkg::DEF_MAX_WIDTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire sdpa_pkg::conv_t in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output sdpa_pkg::emit_t out_item
);
    import sdpa_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    emit_t            item_reg;
    emit_t            item_next;
    logic [IDX_W-1:0] ndig;
    logic [TOT_W-1:0] sign_w;
    logic [TOT_W-1:0] wide_w;
    logic [TOT_W-1:0] digit_w;
    logic [TOT_W-1:0] total;

    assign in_ready = !valid_reg || out_ready;

    // Significant digits; zero still shows one digit.
    always_comb
    begin
        ndig = IDX_W'(1);
        for (int i = 1; i < BCD_DIGITS; i++)
        begin
            if (in_item.bcd[i] != '0)
            begin
                ndig = IDX_W'(i + 1);
            end
        end
    end

    // Width in use, saturated at the maximum; the cap cuts padding, then sign and digits.
    always_comb
    begin
        sign_w  = TOT_W'(in_item.neg);
        wide_w  = TOT_W'(in_item.min_width);
        digit_w = TOT_W'(in_item.min_digits) + sign_w;
        total   = TOT_W'(ndig) + sign_w;
        if (wide_w > total)
        begin
            total = wide_w;
        end
        if (digit_w > total)
        begin
            total = digit_w;
        end
        if (total > TOT_W'(MAX_WIDTH))
        begin
            total = TOT_W'(MAX_WIDTH);
        end
    end

    always_comb
    begin
        item_next.neg    = in_item.neg;
        item_next.total  = total;
        item_next.ndig   = ndig;
        item_next.digits = in_item.bcd;
    end

    // Stage valid bit.
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ src/sdpa_emit.sv @@
// ----------------------------------------------------------------------------
// sdpa_emit
// Character serializer: holds one converted number and sends its sign,
// zero padding and digits via its output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpa_emit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire sdpa_pkg::emit_t               in_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sdpa_pkg::CHAR_W-1:0]        m_char,
    output logic                               m_last
);
    import sdpa_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    emit_t             item_reg;
    logic [TOT_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  rem_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic [CHAR_W-1:0] char_now;
    logic [IDX_W-1:0]  digit_idx;
    logic              adv;
    logic              fire;
    logic              finish;
    logic              load;

    // Handshake: a held number gives a character whenever the output register frees.
    assign adv      = !out_valid_reg || m_ready;
    assign fire     = busy_reg && adv;
    assign finish   = fire && (rem_reg == TOT_W'(1));
    assign in_ready = !busy_reg || finish;
    assign load     = in_valid && in_ready;

    // Character for the current position, counted down from the end.
    assign digit_idx = IDX_W'(rem_reg - TOT_W'(1));

    always_comb
    begin
        priority if (rem_reg <= TOT_W'(item_reg.ndig))
        begin
            char_now = ASCII_ZERO + CHAR_W'(item_reg.digits[digit_idx]);
        end
        else if (item_reg.neg && (rem_reg == item_reg.total))
        begin
            char_now = ASCII_MINUS;
        end
        else
        begin
            char_now = ASCII_ZERO;
        end
    end

    // Control next state.
    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            busy_next = 1'b1;
            rem_next  = in_item.total;
        end
        else if (fire)
        begin
            rem_next = rem_reg - TOT_W'(1);
            if (finish)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign out_valid_next = adv ? fire : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Held number and output character.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
        if (fire)
        begin
            char_reg <= char_now;
            last_reg <= finish;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_char  = char_reg;
    assign m_last  = last_reg;

endmodule

`default_nettype wire

@@ src/sdpa_checker.sv @@
// ----------------------------------------------------------------------------
// sdpa_checker
// Port-level checks on the character stream of the signed decimal padded
// ASCII unit, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sdpa_checker #(
    parameter int MAX_WIDTH = sdpa_pkg::DEF_MAX_WIDTH
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [sdpa_pkg::CHAR_W-1:0] m_tdata,
    input wire logic                        m_tlast
);
    import sdpa_pkg::*;

    logic [TOT_W-1:0] cnt_reg;
    logic [TOT_W-1:0] cnt_next;

    // Characters already taken of the current number.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (m_tvalid && m_tready)
        begin
            cnt_next = m_tlast ? '0 : cnt_reg + TOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled character stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // Only the minus sign or a decimal digit is ever sent.
    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == ASCII_MINUS) ||
                     ((m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_ZERO + 8'd9)))
        else $error("output character out of set");

    // The sign comes first and never ends a number.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == ASCII_MINUS) |-> (cnt_reg == '0) && !m_tlast)
        else $error("minus sign misplaced");

    // A number never grows past the saturation width.
    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt_reg < TOT_W'(MAX_WIDTH)))
        else $error("number longer than maximum width");

endmodule

bind signed_decimal_padded_ascii_unit sdpa_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_sdpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ sim/signed_decimal_padded_ascii_unit_tb.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_padded_ascii_unit_tb
// Self-checking bench for the signed decimal ASCII converter. Each number is
// sent as one stream item. A local model works out the characters that the
// item should produce and queues them. A monitor compares every character
// and its tlast flag with the oldest queued expectation. Both stream sides
// idle in random bursts, except in the final test.
// ----------------------------------------------------------------------------

module signed_decimal_padded_ascii_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sdpa_pkg::*;

    localparam int MAX_W       = 32;
    localparam int LATENCY     = 12;
    localparam int CYCLE_LIMIT = 400000;

    // One expected output character.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } text_char_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [CHAR_W-1:0]   m_tdata;
    logic                m_tlast;

    text_char_t          pending_chars[$];
    bit                  idle_on = 1'b1;
    int                  err_count = 0;
    int                  numbers_sent = 0;
    int                  chars_checked = 0;
    int                  neg_count = 0;
    int                  padded_count = 0;
    int                  saturated_count = 0;
    int                  cycle_count = 0;

    signed_decimal_padded_ascii_unit #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Expected text of one number: sign, zero padding, then the digits.
    function automatic void predict_text(input logic [31:0] value,
                                         input logic [FLD_W-1:0] min_width,
                                         input logic [FLD_W-1:0] min_digits);
        logic [3:0]  digits[10];
        logic [31:0] mag;
        int          ndig;
        int          neg;
        int          total;
        int          pad;
        text_char_t  ch;
        mag  = value[31] ? (32'd0 - value) : value;
        neg  = value[31] ? 1 : 0;
        ndig = 0;
        do begin
            digits[ndig] = 4'(mag % 10);
            mag = mag / 10;
            ndig++;
        end while (mag != 0 && ndig < 10);
        total = ndig + neg;
        if (int'(min_width) > total)
            total = int'(min_width);
        if (int'(min_digits) + neg > total)
            total = int'(min_digits) + neg;
        if (total > MAX_W)
        begin
            total = MAX_W;
            saturated_count++;
        end
        pad = total - ndig - neg;
        if (pad > 0)
            padded_count++;
        neg_count += neg;
        ch.is_last = 1'b0;
        if (neg != 0)
        begin
            ch.code = ASCII_MINUS;
            pending_chars.push_back(ch);
        end
        for (int k = 0; k < pad; k++)
        begin
            ch.code = ASCII_ZERO;
            pending_chars.push_back(ch);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            ch.code = ASCII_ZERO + CHAR_W'(digits[k]);
            ch.is_last = (k == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // Send one item, with an optional idle burst first.
    task automatic send_number(input logic [31:0] value,
                               input logic [FLD_W-1:0] min_width,
                               input logic [FLD_W-1:0] min_digits);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, min_digits, min_width, value};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_text(value, min_width, min_digits);
        numbers_sent++;
    endtask

    // Random value: full range, small, power-of-ten boundaries or extremes.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        longint      p;
        int          k;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = 32'($signed($urandom_range(0, 198)) - 99);
            3:
            begin
                k = $urandom_range(1, 9);
                p = 1;
                repeat (k) p = p * 10;
                v = 32'(p - longint'($urandom_range(0, 1)));
            end
            4: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 1)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 1);
            default: v = $urandom_range(0, 99999);
        endcase
        if ($urandom_range(0, 1) && v != 32'h8000_0000)
            v = 32'd0 - v;
        return v;
    endfunction

    // Field value: mostly in the natural range, sometimes anywhere up to 63.
    function automatic logic [FLD_W-1:0] pick_field();
        if ($urandom_range(0, 4) == 0)
            return FLD_W'($urandom_range(0, 63));
        return FLD_W'($urandom_range(0, 12));
    endfunction

    // Receiver side: ready toggles in random bursts while idling is on.
    initial
    begin
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Compare each accepted output item with the oldest expected character.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("char_out: unexpected item 0x%02h with no character pending", m_tdata);
                err_count++;
            end
            else
            begin
                text_char_t exp_ch;
                exp_ch = pending_chars.pop_front();
                if (m_tdata !== exp_ch.code)
                begin
                    $error("char_out: expected 0x%02h, got 0x%02h", exp_ch.code, m_tdata);
                    err_count++;
                end
                if (m_tlast !== exp_ch.is_last)
                begin
                    $error("last_char: expected %0b, got %0b", exp_ch.is_last, m_tlast);
                    err_count++;
                end
                chars_checked++;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters pending",
                     cycle_count, pending_chars.size());
            $display("FAIL");
            $finish;
        end
    end

    // Extremes of every field, zero, the most negative value and saturation.
    task automatic test_directed();
        send_number(32'd0, 6'd0, 6'd0);
        send_number(32'd0, 6'd5, 6'd0);
        send_number(32'd0, 6'd0, 6'd3);
        send_number(32'd1, 6'd0, 6'd0);
        send_number(-32'sd1, 6'd0, 6'd0);
        send_number(-32'sd1, 6'd4, 6'd0);
        send_number(-32'sd1, 6'd0, 6'd4);
        send_number(32'h7FFF_FFFF, 6'd0, 6'd0);
        send_number(32'h8000_0000, 6'd0, 6'd0);
        send_number(32'h8000_0000, 6'd32, 6'd0);
        send_number(32'h8000_0000, 6'd0, 6'd32);
        send_number(32'd9, 6'd0, 6'd0);
        send_number(32'd10, 6'd0, 6'd0);
        send_number(-32'sd10, 6'd3, 6'd3);
        send_number(32'd999999999, 6'd0, 6'd0);
        send_number(32'd1000000000, 6'd0, 6'd0);
        send_number(-32'sd1000000000, 6'd11, 6'd11);
        send_number(32'd12345, 6'd32, 6'd0);
        send_number(-32'sd12345, 6'd0, 6'd32);
        send_number(32'd7, 6'd63, 6'd0);
        send_number(-32'sd7, 6'd0, 6'd63);
        send_number(-32'sd7, 6'd63, 6'd63);
        send_number(32'd123456789, 6'd12, 6'd10);
        send_number(32'd0, 6'd63, 6'd63);
    endtask

    // Random numbers and widths with idling on both sides.
    task automatic test_random(input int count);
        repeat (count) send_number(pick_value(), pick_field(), pick_field());
    endtask

    // Back-to-back items with the receiver always ready.
    task automatic test_streaming(input int count);
        idle_on = 1'b0;
        repeat (count) send_number(pick_value(), pick_field(), pick_field());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300);
        test_streaming(50);

        // Drain all expected characters, then watch for stray output.
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (3 * LATENCY) @(posedge clk);

        $display("Converted %0d numbers into %0d characters checked.",
                 numbers_sent, chars_checked);
        $display("Negative: %0d, zero padded: %0d, width saturated: %0d, errors: %0d.",
                 neg_count, padded_count, saturated_count, err_count);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/sdpa_pkg.sv
src/sdpa_front.sv
src/sdpa_dabble.sv
src/sdpa_size.sv
src/sdpa_emit.sv
src/signed_decimal_padded_ascii_unit.sv
src/sdpa_checker.sv
sim/signed_decimal_padded_ascii_unit_tb.sv
